@@ rtl/core/fsss_pkg.sv @@
// Package: shared types, constants and the glyph decoder of the seven-segment scanner.
package fsss_pkg;

    localparam int DIGIT_COUNT_DEF = 6;
    localparam int STORE_DEPTH_DEF = 15;
    localparam int DOT_SLOT_DEF    = 8;

    localparam int DIGIT_MAX   = 8;
    localparam int DIGIT_W     = 3;
    localparam int GLYPH_COUNT = 18;
    localparam int SLICE_COUNT = 4;
    localparam int PHASE_W     = 3;
    localparam int CFG_IDX_W   = 2;

    localparam logic [7:0] FRAME_START = 8'h80;
    localparam logic [7:0] FRAME_END   = 8'hFE;
    localparam logic [7:0] BLANK_RST   = 8'd5;
    localparam logic [7:0] SLICE_RST   = 8'd2;
    localparam logic [7:0] DOT_RST     = 8'd8;

    localparam logic [PHASE_W-1:0] PHASE_BLANK = '0;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_TICKS = 2'd1;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         digit_select_n;
        logic [7:0]         segment_drive;
        logic [DIGIT_W-1:0] digit_number;
    } t_out_item;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           data;
    } t_cfg_wr;

    typedef logic [DIGIT_MAX-1:0][7:0] t_digit_array;

    function automatic logic [7:0] glyph(input logic [7:0] code);
        logic [7:0] pat;
        case (code)
            8'd0:    pat = 8'h3f;
            8'd1:    pat = 8'h06;
            8'd2:    pat = 8'h5b;
            8'd3:    pat = 8'h4f;
            8'd4:    pat = 8'h66;
            8'd5:    pat = 8'h6d;
            8'd6:    pat = 8'h7d;
            8'd7:    pat = 8'h07;
            8'd8:    pat = 8'h7f;
            8'd9:    pat = 8'h6f;
            8'd10:   pat = 8'h77;
            8'd11:   pat = 8'h7c;
            8'd12:   pat = 8'h39;
            8'd13:   pat = 8'h5e;
            8'd14:   pat = 8'h79;
            8'd15:   pat = 8'h71;
            8'd16:   pat = 8'h3d;
            8'd17:   pat = 8'h76;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

@@ rtl/core/fsss_receiver.sv @@
// Frame receiver: receive slots, slot index, shown digits and dot position.
module fsss_receiver #(
    parameter int DIGIT_COUNT = fsss_pkg::DIGIT_COUNT_DEF,
    parameter int STORE_DEPTH = fsss_pkg::STORE_DEPTH_DEF,
    parameter int DOT_SLOT    = fsss_pkg::DOT_SLOT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_byte_valid,
    input  logic [7:0]             i_byte,
    output fsss_pkg::t_digit_array o_shown,
    output logic [7:0]             o_dot
);
    import fsss_pkg::*;

    localparam int IDX_W = $clog2(STORE_DEPTH + 1);
    localparam int ADR_W = $clog2(STORE_DEPTH);

    logic [7:0]       r_store [STORE_DEPTH];
    logic [IDX_W-1:0] r_index;
    t_digit_array     r_shown;
    logic [7:0]       r_dot;
    logic [7:0]       n_dot;

    generate
        if (DOT_SLOT < STORE_DEPTH) begin : g_dot_in
            assign n_dot = r_store[ADR_W'(DOT_SLOT)];
        end else begin : g_dot_out
            assign n_dot = 8'd0;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_shown <= '0;
            r_dot   <= DOT_RST;
            for (int k = 0; k < STORE_DEPTH; k++) begin
                r_store[k] <= 8'd0;
            end
        end else if (i_byte_valid) begin
            if (i_byte == FRAME_START) begin
                r_index <= '0;
            end else if (i_byte == FRAME_END) begin
                for (int m = 0; m < DIGIT_COUNT; m++) begin
                    r_shown[m] <= r_store[m];
                end
                r_dot   <= n_dot;
                r_index <= '0;
            end else if (r_index < IDX_W'(STORE_DEPTH)) begin
                r_store[r_index[ADR_W-1:0]] <= i_byte;
                r_index <= r_index + 1'b1;
            end
        end
    end

    assign o_shown = r_shown;
    assign o_dot   = r_dot;

    property p_index_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_index <= IDX_W'(STORE_DEPTH);
    endproperty
    a_index_bound: assert property (p_index_bound)
        else $error("receive index beyond store depth");

    property p_frame_end_clears;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_byte_valid && i_byte == FRAME_END) |=> (r_index == '0);
    endproperty
    a_frame_end_clears: assert property (p_frame_end_clears)
        else $error("frame end did not restart the slot index");

endmodule

@@ rtl/core/fsss_scanner.sv @@
// Scanner: tick timing registers, scan position and segment pattern of one tick.
module fsss_scanner #(
    parameter int DIGIT_COUNT = fsss_pkg::DIGIT_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_tick,
    input  fsss_pkg::t_cfg_wr      i_cfg,
    input  fsss_pkg::t_digit_array i_shown,
    input  logic [7:0]             i_dot,
    output fsss_pkg::t_out_item    o_result
);
    import fsss_pkg::*;

    logic [7:0]         r_blank_ticks;
    logic [7:0]         r_slice_ticks;
    logic [DIGIT_W-1:0] r_scan_digit;
    logic [PHASE_W-1:0] r_scan_phase;
    logic [7:0]         r_phase_ticks;

    logic [DIGIT_W-1:0] n_scan_digit;
    logic [PHASE_W-1:0] n_scan_phase;
    logic [7:0]         n_phase_ticks;

    logic [7:0]         len;
    logic [8:0]         ticks_inc;
    logic [DIGIT_W:0]   digit_inc;
    logic [7:0]         code;
    logic [7:0]         pattern;
    logic [1:0]         slice;
    logic [7:0]         mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_ticks <= BLANK_RST;
            r_slice_ticks <= SLICE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_BLANK_TICKS: r_blank_ticks <= i_cfg.data;
                CFG_SLICE_TICKS: r_slice_ticks <= i_cfg.data;
                default:         ;
            endcase
        end
    end

    always_comb begin
        len = (r_scan_phase == PHASE_BLANK) ? r_blank_ticks : r_slice_ticks;
        if (len == 8'd0) begin
            len = 8'd1;
        end
        ticks_inc     = {1'b0, r_phase_ticks} + 9'd1;
        digit_inc     = {1'b0, r_scan_digit} + 1'b1;
        n_phase_ticks = ticks_inc[7:0];
        n_scan_phase  = r_scan_phase;
        n_scan_digit  = r_scan_digit;
        if (ticks_inc >= {1'b0, len}) begin
            n_phase_ticks = 8'd0;
            if (r_scan_phase >= PHASE_W'(SLICE_COUNT)) begin
                n_scan_phase = PHASE_BLANK;
                if (digit_inc >= (DIGIT_W + 1)'(DIGIT_COUNT)) begin
                    n_scan_digit = '0;
                end else begin
                    n_scan_digit = digit_inc[DIGIT_W-1:0];
                end
            end else begin
                n_scan_phase = r_scan_phase + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_digit  <= '0;
            r_scan_phase  <= PHASE_BLANK;
            r_phase_ticks <= 8'd0;
        end else if (i_tick) begin
            r_scan_digit  <= n_scan_digit;
            r_scan_phase  <= n_scan_phase;
            r_phase_ticks <= n_phase_ticks;
        end
    end

    always_comb begin
        code    = i_shown[r_scan_digit];
        pattern = glyph(code);
        if (code < 8'(GLYPH_COUNT) && i_dot == 8'(r_scan_digit)) begin
            pattern[7] = 1'b1;
        end
        slice = 2'(r_scan_phase - 1'b1);
        mask  = 8'b11 << {slice, 1'b0};
        o_result.digit_select_n = ~(8'd1 << r_scan_digit);
        o_result.segment_drive  = (r_scan_phase == PHASE_BLANK) ? 8'd0 : (pattern & mask);
        o_result.digit_number   = r_scan_digit;
    end

    property p_phase_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_scan_phase <= PHASE_W'(SLICE_COUNT);
    endproperty
    a_phase_bound: assert property (p_phase_bound)
        else $error("scan phase beyond last slice");

    property p_digit_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
            {1'b0, r_scan_digit} < (DIGIT_W + 1)'(DIGIT_COUNT);
    endproperty
    a_digit_bound: assert property (p_digit_bound)
        else $error("scan digit beyond digit count");

endmodule

@@ rtl/core/fsss_skid.sv @@
// Output stage: result register plus skid register toward the output channel.
module fsss_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fsss_pkg::t_out_item i_data,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output fsss_pkg::t_out_item o_data
);
    import fsss_pkg::*;

    logic      r_main_valid;
    logic      r_skid_valid;
    t_out_item r_main;
    t_out_item r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || !i_stall) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    property p_skid_needs_main;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_skid_valid |-> r_main_valid;
    endproperty
    a_skid_needs_main: assert property (p_skid_needs_main)
        else $error("skid register holds an item while result register is empty");

    property p_push_lands;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_push |=> r_main_valid;
    endproperty
    a_push_lands: assert property (p_push_lands)
        else $error("pushed item was lost");

endmodule

@@ rtl/core/framed_seven_segment_scanner.sv @@
// Top level: framed serial bytes in, one multiplexed seven-segment scan item per tick out.
// Every input item, byte or tick, is taken while o_in_stall is low; a new one can follow in
// the next cycle; a tick's scan item goes into the output or skid register, bytes give
// none. The output register and a one-entry skid register let the input keep flowing for one
// extra result while the output is stalled; o_in_stall rises only when that skid register is
// occupied. Configuration writes are always ready and take effect on the next tick.
module framed_seven_segment_scanner #(
    parameter int DIGIT_COUNT = fsss_pkg::DIGIT_COUNT_DEF,
    parameter int STORE_DEPTH = fsss_pkg::STORE_DEPTH_DEF,
    parameter int DOT_SLOT    = fsss_pkg::DOT_SLOT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  fsss_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output fsss_pkg::t_out_item                o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fsss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [7:0]                         i_cfg_data
);
    import fsss_pkg::*;

    logic         in_accept;
    logic         byte_valid;
    logic         tick;
    logic         skid_full;
    t_cfg_wr      cfg;
    t_digit_array shown;
    logic [7:0]   dot;
    t_out_item    result;

    assign o_in_stall  = skid_full;
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !skid_full;
    assign byte_valid  = in_accept && (i_in_data.operation == OP_BYTE);
    assign tick        = in_accept && (i_in_data.operation == OP_TICK);

    assign cfg.valid = i_cfg_valid;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    fsss_receiver #(
        .DIGIT_COUNT (DIGIT_COUNT),
        .STORE_DEPTH (STORE_DEPTH),
        .DOT_SLOT    (DOT_SLOT)
    ) u_receiver (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (byte_valid),
        .i_byte       (i_in_data.rx_byte),
        .o_shown      (shown),
        .o_dot        (dot)
    );

    fsss_scanner #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_scanner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick),
        .i_cfg    (cfg),
        .i_shown  (shown),
        .i_dot    (dot),
        .o_result (result)
    );

    fsss_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tick),
        .i_data  (result),
        .o_full  (skid_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule
